/* rtl/fcc_pkg.sv */
// Package for the fallback calendar clock: time record and input item types,
// calendar limits and the month length function. No dependencies.
package fcc_pkg;

    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned MINUTES_PER_HOUR   = 60;
    localparam int unsigned HOURS_PER_DAY      = 24;
    localparam int unsigned MONTHS_PER_YEAR    = 12;

    localparam logic [4:0] DAYS_LONG      = 5'd31;
    localparam logic [4:0] DAYS_SHORT     = 5'd30;
    localparam logic [4:0] DAYS_FEB_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_FEB       = 5'd28;
    localparam logic [4:0] DAYS_NONE      = 5'd0;

    localparam logic [3:0] MONTH_FEB = 4'd1;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
    } fcc_time_t;

    typedef struct packed {
        logic       rtc_valid;
        logic [4:0] rtc_hours;
        logic [5:0] rtc_minutes;
        logic [5:0] rtc_seconds;
        logic [4:0] rtc_day_of_month;
        logic [3:0] rtc_month;
        logic [7:0] rtc_year;
        logic       in_game;
    } fcc_item_t;

    // Year 0 (1900) is not a leap year; other multiples of four are.
    function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                 input logic [7:0] year);
        logic [4:0] days;
        case (month)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = DAYS_LONG;
            4'd3, 4'd5, 4'd8, 4'd10:                   days = DAYS_SHORT;
            MONTH_FEB: days = (year[1:0] == 2'b00 && year != 8'd0)
                              ? DAYS_FEB_LEAP : DAYS_FEB;
            default:                                   days = DAYS_NONE;
        endcase
        return days;
    endfunction

endpackage

/* rtl/fcc_calendar.sv */
// One-second advance of the kept time: seconds carry through minutes, hours,
// day of month, month and wrapping year. Depends on fcc_pkg.
module fcc_calendar (
    input  fcc_pkg::fcc_time_t cur,
    output fcc_pkg::fcc_time_t nxt
);
    import fcc_pkg::*;

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [4:0] dim;

    assign sec_inc   = {1'b0, cur.seconds} + 7'd1;
    assign min_inc   = {1'b0, cur.minutes} + 7'd1;
    assign hour_inc  = {1'b0, cur.hours} + 6'd1;
    assign day_inc   = {1'b0, cur.day} + 6'd1;
    assign month_inc = {1'b0, cur.month} + 5'd1;
    assign dim       = days_in_month(cur.month, cur.year);

    always_comb
    begin
        nxt = cur;
        if (sec_inc < 7'(SECONDS_PER_MINUTE))
        begin
            nxt.seconds = sec_inc[5:0];
        end
        else
        begin
            nxt.seconds = '0;
            if (min_inc < 7'(MINUTES_PER_HOUR))
            begin
                nxt.minutes = min_inc[5:0];
            end
            else
            begin
                nxt.minutes = '0;
                if (hour_inc < 6'(HOURS_PER_DAY))
                begin
                    nxt.hours = hour_inc[4:0];
                end
                else
                begin
                    nxt.hours = '0;
                    if (day_inc < {1'b0, dim})
                    begin
                        nxt.day = day_inc[4:0];
                    end
                    else
                    begin
                        nxt.day = '0;
                        if (month_inc < 5'(MONTHS_PER_YEAR))
                        begin
                            nxt.month = month_inc[3:0];
                        end
                        else
                        begin
                            nxt.month = '0;
                            nxt.year  = cur.year + 8'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

/* rtl/fallback_calendar_clock.sv */
// Top level of the fallback calendar clock: input register, frame counter,
// failure mark, kept time and result register. Depends on fcc_pkg, fcc_calendar.
//
// Usage:
//   Each request on the input channel (in_valid/in_ready) is one video frame
//   tick with a snapshot of the external RTC. Each tick yields exactly one
//   result on the output channel (out_valid/out_ready): the kept time after
//   the tick, the sticky RTC failure mark and a play-time pulse.
//   The frame counter marks a second every FRAMES_PER_SECOND ticks and checks
//   the RTC every second second; a stuck or missing RTC seconds value sets
//   rtc_failed for good, after which the block counts its own calendar.
//   While the RTC is good the kept time is loaded from each valid snapshot.
//   The tick lands in the input register, and the result register loads from
//   it once the result register is free (empty or being read).
//   Throughput: one tick per cycle while the receiver does not stall; the whole
//   per-tick update is one pass of combinational logic between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register holds one more tick; in_ready drops once both are full.
//   Reset clears the counter, the failure mark and the kept time to zero
//   and empties both registers.
module fallback_calendar_clock #(
    parameter int unsigned FRAMES_PER_SECOND = 60
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       rtc_valid,
    input  logic [4:0] rtc_hours,
    input  logic [5:0] rtc_minutes,
    input  logic [5:0] rtc_seconds,
    input  logic [4:0] rtc_day_of_month,
    input  logic [3:0] rtc_month,
    input  logic [7:0] rtc_year,
    input  logic       in_game,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] hours,
    output logic [5:0] minutes,
    output logic [5:0] seconds,
    output logic [4:0] day_index,
    output logic [3:0] month_index,
    output logic [7:0] year_offset,
    output logic       rtc_failed,
    output logic       play_second_tick
);
    import fcc_pkg::*;

    localparam int unsigned CW = $clog2(2 * FRAMES_PER_SECOND + 1);
    localparam logic [CW-1:0] FPS_COUNT   = CW'(FRAMES_PER_SECOND);
    localparam logic [CW-1:0] CHECK_COUNT = CW'(2 * FRAMES_PER_SECOND);

    fcc_item_t     item_reg;
    logic          item_valid_reg;
    logic          out_valid_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          failed_reg, failed_next;
    fcc_time_t     time_reg, time_next;
    fcc_time_t     time_adv;
    logic          pulse_reg, pulse_next;

    logic          out_free;
    logic          advance;
    logic [CW-1:0] count_inc;
    logic          sec_boundary;
    logic          check;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;

    fcc_calendar u_calendar (
        .cur (time_reg),
        .nxt (time_adv)
    );

    always_comb
    begin
        count_inc    = count_reg + CW'(1);
        sec_boundary = (count_inc == FPS_COUNT) || (count_inc == CHECK_COUNT);
        check        = (count_inc == CHECK_COUNT);
        count_next   = check ? '0 : count_inc;
        failed_next  = failed_reg ||
                       (check && (!item_reg.rtc_valid ||
                                  time_reg.seconds == item_reg.rtc_seconds));
        pulse_next   = sec_boundary && item_reg.in_game;

        time_next = time_reg;
        if (sec_boundary && failed_next)
        begin
            time_next = time_adv;
        end
        if (!failed_next && item_reg.rtc_valid)
        begin
            time_next.hours   = item_reg.rtc_hours;
            time_next.minutes = item_reg.rtc_minutes;
            time_next.seconds = item_reg.rtc_seconds;
            // one-based day to zero-based, day zero wraps
            time_next.day     = item_reg.rtc_day_of_month - 5'd1;
            time_next.month   = item_reg.rtc_month;
            time_next.year    = item_reg.rtc_year;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            failed_reg     <= 1'b0;
            time_reg       <= '0;
            pulse_reg      <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                failed_reg    <= failed_next;
                time_reg      <= time_next;
                pulse_reg     <= pulse_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.rtc_valid        <= rtc_valid;
            item_reg.rtc_hours        <= rtc_hours;
            item_reg.rtc_minutes      <= rtc_minutes;
            item_reg.rtc_seconds      <= rtc_seconds;
            item_reg.rtc_day_of_month <= rtc_day_of_month;
            item_reg.rtc_month        <= rtc_month;
            item_reg.rtc_year         <= rtc_year;
            item_reg.in_game          <= in_game;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hours            = time_reg.hours;
    assign minutes          = time_reg.minutes;
    assign seconds          = time_reg.seconds;
    assign day_index        = time_reg.day;
    assign month_index      = time_reg.month;
    assign year_offset      = time_reg.year;
    assign rtc_failed       = failed_reg;
    assign play_second_tick = pulse_reg;

endmodule
